FILE: sv/hed_pkg.sv
// Shared types and constants for the HTML entity decoder.
// The entity table, the held-prefix and result-list types live here.
// No dependencies; used by hed_decode and html_entity_decoder_top.
package hed_pkg;

    localparam int HOLD_DEPTH = 5;
    localparam int RES_MAX    = 6;
    localparam int ENT_NUM    = 7;
    localparam int ENT_MAXLEN = 6;
    localparam int CAP_W      = 11;
    localparam int CNT_W      = 3;

    localparam logic [CAP_W-1:0] CAP_MAX = 11'd2047;
    localparam logic [7:0]       AMP     = 8'h26;

    // Entity spellings, padded with zero after the closing semicolon.
    localparam logic [7:0] ENT_TEXT [ENT_NUM][ENT_MAXLEN] = '{
        '{8'h26, 8'h6C, 8'h74, 8'h3B, 8'h00, 8'h00},   // &lt;
        '{8'h26, 8'h67, 8'h74, 8'h3B, 8'h00, 8'h00},   // &gt;
        '{8'h26, 8'h61, 8'h6D, 8'h70, 8'h3B, 8'h00},   // &amp;
        '{8'h26, 8'h71, 8'h75, 8'h6F, 8'h74, 8'h3B},   // &quot;
        '{8'h26, 8'h23, 8'h33, 8'h39, 8'h3B, 8'h00},   // &#39;
        '{8'h26, 8'h23, 8'h30, 8'h33, 8'h39, 8'h3B},   // &#039;
        '{8'h26, 8'h6E, 8'h62, 8'h73, 8'h70, 8'h3B}    // &nbsp;
    };

    localparam logic [CNT_W-1:0] ENT_LEN [ENT_NUM] = '{
        3'd4, 3'd4, 3'd5, 3'd6, 3'd5, 3'd6, 3'd6
    };

    localparam logic [7:0] ENT_BYTE [ENT_NUM] = '{
        8'h3C, 8'h3E, 8'h26, 8'h22, 8'h27, 8'h27, 8'h20
    };

    typedef struct packed {
        logic [HOLD_DEPTH-1:0][7:0] bytes;
        logic [CNT_W-1:0]           count;
    } hold_t;

    typedef struct packed {
        logic [RES_MAX-1:0][7:0] bytes;
        logic [CNT_W-1:0]        count;
        logic                    bare;
        logic                    last;
    } res_t;

endpackage

FILE: sv/hed_decode.sv
// Single-pass decode of one input item: entity match, flush list and cap.
// Produces the result list, the next held prefix and the next emitted count.
// Depends on hed_pkg.
module hed_decode (
    input  hed_pkg::hold_t                 held,
    input  logic [7:0]                     text_byte,
    input  logic                           byte_present,
    input  logic                           end_of_string,
    input  logic [hed_pkg::CAP_W-1:0]      cap,
    input  logic [hed_pkg::CAP_W-1:0]      emitted,
    output hed_pkg::res_t                  res,
    output hed_pkg::hold_t                 held_next,
    output logic [hed_pkg::CAP_W-1:0]      emitted_next
);

    logic [hed_pkg::ENT_NUM-1:0] ent_ok;
    logic [hed_pkg::ENT_NUM-1:0] ent_full;
    logic                        full;
    logic                        use_full;
    logic                        partial;
    logic                        hold_ok;
    logic [7:0]                  full_byte;
    logic [hed_pkg::CNT_W-1:0]   hc_out;
    logic                        append_c;
    logic [hed_pkg::CNT_W-1:0]   list_n;
    logic [hed_pkg::CNT_W-1:0]   take_n;
    logic [hed_pkg::CAP_W-1:0]   room;

    // Held bytes plus the new byte are compared against every entity at once.
    always_comb
    begin
        for (int e = 0; e < hed_pkg::ENT_NUM; e++)
        begin
            ent_ok[e] = (held.count < hed_pkg::ENT_LEN[e]);
            for (int k = 0; k < hed_pkg::HOLD_DEPTH; k++)
            begin
                if ((3'(k) < held.count) && (held.bytes[k] != hed_pkg::ENT_TEXT[e][k]))
                begin
                    ent_ok[e] = 1'b0;
                end
            end
            for (int k = 0; k < hed_pkg::ENT_MAXLEN; k++)
            begin
                if ((3'(k) == held.count) && (hed_pkg::ENT_TEXT[e][k] != text_byte))
                begin
                    ent_ok[e] = 1'b0;
                end
            end
            ent_full[e] = ent_ok[e] && ((held.count + 3'd1) == hed_pkg::ENT_LEN[e]);
        end

        // The first entity in table order wins on a full match.
        full_byte = 8'h00;
        for (int e = hed_pkg::ENT_NUM - 1; e >= 0; e--)
        begin
            if (ent_full[e])
            begin
                full_byte = hed_pkg::ENT_BYTE[e];
            end
        end
        full     = |ent_full;
        use_full = byte_present && full;
        partial  = |(ent_ok & ~ent_full);
        hold_ok  = partial && (held.count < 3'(hed_pkg::HOLD_DEPTH));
    end

    // Every non-match result list is the held prefix, optionally followed by the new byte.
    always_comb
    begin
        hc_out   = (end_of_string || (byte_present && !hold_ok)) ? held.count : '0;
        append_c = byte_present && !full
                   && (end_of_string || (!hold_ok && (text_byte != hed_pkg::AMP)));
        list_n   = use_full ? 3'd1 : (hc_out + {2'b00, append_c});

        for (int j = 0; j < hed_pkg::RES_MAX; j++)
        begin
            res.bytes[j] = text_byte;
        end
        for (int j = 0; j < hed_pkg::HOLD_DEPTH; j++)
        begin
            if (3'(j) < hc_out)
            begin
                res.bytes[j] = held.bytes[j];
            end
        end
        if (use_full)
        begin
            res.bytes[0] = full_byte;
        end

        // Bytes past the cap are dropped; the list is always cut at its tail.
        room   = (emitted >= cap) ? '0 : (cap - emitted);
        take_n = (room < 11'(list_n)) ? room[hed_pkg::CNT_W-1:0] : list_n;

        res.count    = take_n;
        res.bare     = end_of_string && (take_n == '0);
        res.last     = end_of_string;
        emitted_next = end_of_string ? '0 : (emitted + 11'(take_n));
    end

    always_comb
    begin
        held_next = held;
        if (end_of_string)
        begin
            held_next.count = '0;
        end
        else if (byte_present)
        begin
            if (use_full)
            begin
                held_next.count = '0;
            end
            else if (hold_ok)
            begin
                for (int k = 0; k < hed_pkg::HOLD_DEPTH; k++)
                begin
                    if (3'(k) == held.count)
                    begin
                        held_next.bytes[k] = text_byte;
                    end
                end
                held_next.count = held.count + 3'd1;
            end
            else if (text_byte == hed_pkg::AMP)
            begin
                held_next.bytes[0] = text_byte;
                held_next.count    = 3'd1;
            end
            else
            begin
                held_next.count = '0;
            end
        end
    end

endmodule

FILE: sv/html_entity_decoder_top.sv
// Top level of the streaming HTML entity decoder.
// Input stage, decode state, result list buffer and configuration register.
// Depends on hed_pkg and hed_decode.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+------------------------------------------
//   input    | in_valid / in_stall       | text_byte, byte_present, end_of_string
//   output   | out_valid / out_stall     | out_byte, out_present, out_last
//   config   | cfg_write                 | cfg_data (max_output_bytes)
//
// An item leaves the input register for decode once the result list buffer is empty
// or drains. The buffer hands out one result per cycle (up to six per item) through
// its single output port while out_stall is low. The input register takes a new item
// while results still wait. Reset clears the held count, the emitted count and the
// handshake state and sets the cap to 2047. A stall on the output holds the buffer
// and, once the input register is full, the input side.
module html_entity_decoder_top #(
    parameter int BUFFER_BYTES = 2048
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write,
    input  logic [hed_pkg::CAP_W-1:0]    cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [7:0]                   text_byte,
    input  logic                         byte_present,
    input  logic                         end_of_string,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [7:0]                   out_byte,
    output logic                         out_present,
    output logic                         out_last
);

    localparam logic [hed_pkg::CAP_W-1:0] CAP_LIM =
        (BUFFER_BYTES - 1 > int'(hed_pkg::CAP_MAX)) ? hed_pkg::CAP_MAX
                                                   : hed_pkg::CAP_W'(BUFFER_BYTES - 1);

    logic [hed_pkg::CAP_W-1:0]  max_bytes_reg;
    logic [hed_pkg::CAP_W-1:0]  cap;

    logic                       stg_valid_reg;
    logic [7:0]                 stg_byte_reg;
    logic                       stg_present_reg;
    logic                       stg_eos_reg;

    hed_pkg::hold_t             held_reg;
    hed_pkg::hold_t             held_next;
    logic [hed_pkg::CAP_W-1:0]  emitted_reg;
    logic [hed_pkg::CAP_W-1:0]  emitted_next;
    hed_pkg::res_t              res;

    logic [hed_pkg::RES_MAX-1:0][7:0] buf_bytes_reg;
    logic [hed_pkg::CNT_W-1:0]        buf_rem_reg;
    logic [hed_pkg::CNT_W-1:0]        buf_ptr_reg;
    logic                             buf_last_reg;
    logic                             buf_bare_reg;

    logic in_xfer;
    logic out_xfer;
    logic advance;

    assign cap = (max_bytes_reg < CAP_LIM) ? max_bytes_reg : CAP_LIM;

    assign out_valid   = (buf_rem_reg != '0);
    assign out_xfer    = out_valid && !out_stall;
    assign out_byte    = buf_bare_reg ? 8'h00 : buf_bytes_reg[buf_ptr_reg];
    assign out_present = !buf_bare_reg;
    assign out_last    = buf_last_reg && (buf_rem_reg == 3'd1);

    // The staged item moves into decode once the buffer is empty or drains this cycle.
    assign advance  = stg_valid_reg
                      && ((buf_rem_reg == '0) || ((buf_rem_reg == 3'd1) && !out_stall));
    assign in_stall = stg_valid_reg && !advance;
    assign in_xfer  = in_valid && !in_stall;

    hed_decode u_decode (
        .held          (held_reg),
        .text_byte     (stg_byte_reg),
        .byte_present  (stg_present_reg),
        .end_of_string (stg_eos_reg),
        .cap           (cap),
        .emitted       (emitted_reg),
        .res           (res),
        .held_next     (held_next),
        .emitted_next  (emitted_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_bytes_reg <= hed_pkg::CAP_MAX;
        end
        else if (cfg_write)
        begin
            max_bytes_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            stg_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            stg_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            stg_byte_reg    <= text_byte;
            stg_present_reg <= byte_present;
            stg_eos_reg     <= end_of_string;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg    <= '0;
            emitted_reg <= '0;
        end
        else if (advance)
        begin
            held_reg    <= held_next;
            emitted_reg <= emitted_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_rem_reg  <= '0;
            buf_ptr_reg  <= '0;
            buf_last_reg <= 1'b0;
            buf_bare_reg <= 1'b0;
        end
        else if (advance)
        begin
            buf_rem_reg  <= res.bare ? 3'd1 : res.count;
            buf_ptr_reg  <= '0;
            buf_last_reg <= res.last;
            buf_bare_reg <= res.bare;
        end
        else if (out_xfer)
        begin
            buf_rem_reg <= buf_rem_reg - 3'd1;
            buf_ptr_reg <= buf_ptr_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            buf_bytes_reg <= res.bytes;
        end
    end

    // The held prefix never grows past the hold store.
    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg.count <= 3'(hed_pkg::HOLD_DEPTH))
        else $error("held count exceeds hold depth");

    // The read pointer and the remaining count together stay inside the result list.
    a_buf_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (4'(buf_ptr_reg) + 4'(buf_rem_reg)) <= 4'(hed_pkg::RES_MAX))
        else $error("result buffer pointer out of range");

    // A bare end marker is only ever the final transfer of a string.
    a_bare_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_present) |-> out_last)
        else $error("bare marker without last");

    // Finishing a string clears the emitted count and the held prefix.
    a_eos_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && stg_eos_reg) |=> ((emitted_reg == '0) && (held_reg.count == '0)))
        else $error("end of string did not clear state");

endmodule
